[sv/ppt_pkg.sv]
`default_nettype none

package ppt_pkg;

  localparam logic [31:0] MagicWord    = 32'h4453_4831;
  localparam logic [7:0]  MinFrameLen  = 8'd13;
  localparam logic [31:0] TimeoutReset = 32'd10000;

  // Configuration register indexes
  localparam logic CfgOwnId   = 1'b0;
  localparam logic CfgTimeout = 1'b1;

  // Result status codes
  localparam logic [2:0] StTick    = 3'd0;
  localparam logic [2:0] StReject  = 3'd1;
  localparam logic [2:0] StRefresh = 3'd2;
  localparam logic [2:0] StAdded   = 3'd3;
  localparam logic [2:0] StFull    = 3'd4;

  typedef struct packed {
    logic        action;
    logic [31:0] now_ms;
    logic [7:0]  frame_len;
    logic [31:0] frame_magic;
    logic [31:0] sender_id;
  } in_item_t;

  typedef struct packed {
    logic [2:0] status;
    logic [3:0] peer_total;
    logic [3:0] pruned_total;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic scan;
    logic finish;
  } ctl_cmd_t;

  typedef struct packed {
    logic scan_done;
  } ctl_sts_t;

endpackage

`default_nettype wire

[sv/peer_presence_table_with_aging_unit.sv]
`default_nettype none

// Peer table with timeout aging. A transaction is taken when start is high and busy is low;
// the block then stays busy while a scan walks the entry memory one entry per cycle,
// matching the sender and compacting the survivors in the same pass, and while a finish
// step adds the new sender if one is due and registers the result. The result appears on
// result_o for exactly one cycle with done_o high; there is no back-pressure, so the
// receiver must take it in that cycle.
// Configuration writes are always accepted and must only be made while busy is low.
module peer_presence_table_with_aging_unit #(
  parameter int MaxPeers = 8
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_valid_i,
  output logic                   cfg_ready_o,
  input  wire logic              cfg_index_i,
  input  wire logic [31:0]       cfg_data_i,
  input  wire logic              start,
  output logic                   busy,
  input  wire ppt_pkg::in_item_t item_i,
  output logic                   done_o,
  output ppt_pkg::out_item_t     result_o
);
  import ppt_pkg::*;

  ctl_cmd_t cmd;
  ctl_sts_t sts;

  assign cfg_ready_o = 1'b1;

  ppt_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .cmd_o  (cmd),
    .sts_i  (sts)
  );

  ppt_datapath #(
    .MaxPeers (MaxPeers)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .item_i      (item_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .done_o      (done_o),
    .result_o    (result_o)
  );

endmodule

`default_nettype wire

[sv/ppt_ctrl.sv]
`default_nettype none

module ppt_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start,
  output logic                   busy,
  output ppt_pkg::ctl_cmd_t      cmd_o,
  input  wire ppt_pkg::ctl_sts_t sts_i
);
  import ppt_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SCAN   = 3'b010,
    S_FINISH = 3'b100
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.scan_done) begin
          state_d = S_FINISH;
        end
      end
      S_FINISH: begin
        cmd_o.finish = 1'b1;
        state_d      = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy = (state_q != S_IDLE);

endmodule

`default_nettype wire

[sv/ppt_datapath.sv]
`default_nettype none

module ppt_datapath #(
  parameter int MaxPeers = 8
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic              cfg_index_i,
  input  wire logic [31:0]       cfg_data_i,
  input  wire ppt_pkg::in_item_t item_i,
  input  wire ppt_pkg::ctl_cmd_t cmd_i,
  output ppt_pkg::ctl_sts_t      sts_o,
  output logic                   done_o,
  output ppt_pkg::out_item_t     result_o
);
  import ppt_pkg::*;

  localparam int CntW = $clog2(MaxPeers + 1);
  localparam int IdxW = (MaxPeers > 1) ? $clog2(MaxPeers) : 1;
  localparam logic [CntW-1:0] MaxCnt = CntW'(MaxPeers);

  logic [31:0] own_id_q, timeout_q;

  in_item_t    item_q;
  logic        frame_ok_q;
  logic [CntW-1:0] count_q, rd_cnt_q, kept_q;
  logic        vld_q, hit_q, done_q;
  out_item_t   result_q;

  logic [31:0] id_mem [MaxPeers];
  logic [31:0] ls_mem [MaxPeers];
  logic [31:0] id_rd_q, ls_rd_q;

  logic        rd_en;
  logic        match, keep, add, add_keep;
  logic [31:0] eff_seen, age;
  logic        wr_en;
  logic [CntW-1:0] wr_cnt;
  logic [31:0] wr_id, wr_seen;
  logic [CntW-1:0] kept_final, pruned;
  logic [2:0]  status;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_id_q  <= '0;
      timeout_q <= TimeoutReset;
    end else if (cfg_we_i) begin
      if (cfg_index_i == CfgOwnId) begin
        own_id_q <= cfg_data_i;
      end
      if (cfg_index_i == CfgTimeout) begin
        timeout_q <= cfg_data_i;
      end
    end
  end

  assign rd_en = cmd_i.scan && (rd_cnt_q < count_q);

  // The entry in flight is compared with the sender and aged; a refreshed entry ages from now.
  assign match    = frame_ok_q && (id_rd_q == item_q.sender_id);
  assign eff_seen = match ? item_q.now_ms : ls_rd_q;
  assign age      = item_q.now_ms - eff_seen;
  assign keep     = age < timeout_q;

  assign add      = frame_ok_q && !hit_q && (count_q < MaxCnt);
  assign add_keep = add && (timeout_q != '0);

  always_comb begin
    wr_en   = 1'b0;
    wr_cnt  = kept_q;
    wr_id   = id_rd_q;
    wr_seen = eff_seen;
    if (cmd_i.scan && vld_q && keep) begin
      wr_en = 1'b1;
    end else if (cmd_i.finish && add_keep) begin
      wr_en   = 1'b1;
      wr_id   = item_q.sender_id;
      wr_seen = item_q.now_ms;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      id_mem[wr_cnt[IdxW-1:0]] <= wr_id;
      ls_mem[wr_cnt[IdxW-1:0]] <= wr_seen;
    end
    if (rd_en) begin
      id_rd_q <= id_mem[rd_cnt_q[IdxW-1:0]];
      ls_rd_q <= ls_mem[rd_cnt_q[IdxW-1:0]];
    end
  end

  assign kept_final = kept_q + CntW'(add_keep);
  assign pruned     = count_q - kept_q + CntW'(add && !add_keep);

  always_comb begin
    if (item_q.action) begin
      status = StTick;
    end else if (!frame_ok_q) begin
      status = StReject;
    end else if (hit_q) begin
      status = StRefresh;
    end else if (add) begin
      status = StAdded;
    end else begin
      status = StFull;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      item_q     <= item_i;
      frame_ok_q <= !item_i.action && (item_i.frame_len >= MinFrameLen)
                    && (item_i.frame_magic == MagicWord) && (item_i.sender_id != own_id_q);
    end
    if (cmd_i.finish) begin
      result_q.status       <= status;
      result_q.peer_total   <= 4'(kept_final);
      result_q.pruned_total <= 4'(pruned);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      rd_cnt_q <= '0;
      kept_q   <= '0;
      vld_q    <= 1'b0;
      hit_q    <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      done_q <= cmd_i.finish;
      vld_q  <= rd_en;
      if (cmd_i.load) begin
        rd_cnt_q <= '0;
        kept_q   <= '0;
        hit_q    <= 1'b0;
      end
      if (rd_en) begin
        rd_cnt_q <= rd_cnt_q + CntW'(1);
      end
      if (cmd_i.scan && vld_q) begin
        if (keep) begin
          kept_q <= kept_q + CntW'(1);
        end
        if (match) begin
          hit_q <= 1'b1;
        end
      end
      if (cmd_i.finish) begin
        count_q <= kept_final;
      end
    end
  end

  assign sts_o.scan_done = (rd_cnt_q == count_q) && !vld_q;
  assign done_o          = done_q;
  assign result_o        = result_q;

endmodule

`default_nettype wire

[test/tb_peer_presence_table_with_aging_unit.sv]
module tb_peer_presence_table_with_aging_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import ppt_pkg::*;

  localparam int PeerSlots  = 8;
  localparam int PoolSize   = 10;
  localparam int CycleLimit = 600000;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic        cfg_index_i = CfgOwnId;
  logic [31:0] cfg_data_i  = '0;
  logic        start       = 1'b0;
  logic        busy;
  in_item_t    item_i      = '0;
  logic        done_o;
  out_item_t   result_o;

  peer_presence_table_with_aging_unit #(
    .MaxPeers(PeerSlots)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .start      (start),
    .busy       (busy),
    .item_i     (item_i),
    .done_o     (done_o),
    .result_o   (result_o)
  );

  // Shadow copy of the peer table and its registers.
  logic [31:0] own_id_cfg  = '0;
  logic [31:0] timeout_cfg = TimeoutReset;
  logic [31:0] peer_ids  [PeerSlots];
  logic [31:0] peer_seen [PeerSlots];
  int          peer_count = 0;

  in_item_t    frames_to_send[$];
  out_item_t   due_peer_reports[$];
  bit          sender_gaps = 1'b1;
  int          err_count   = 0;
  int          cycle_count = 0;
  logic [31:0] now_cursor  = '0;
  logic [31:0] id_pool [PoolSize];

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  task automatic flag_mismatch(string what, int got, int want);
    err_count++;
    $display("%0t: mismatch in %s: got %0d, expected %0d", $time, what, got, want);
  endtask

  function automatic out_item_t apply_to_peer_table(in_item_t it);
    out_item_t   r;
    logic [31:0] age;
    int          kept;
    int          prev;
    bit          hit;
    r.status = StTick;
    if (it.action == 1'b0) begin
      if (it.frame_len < MinFrameLen || it.frame_magic != MagicWord ||
          it.sender_id == own_id_cfg) begin
        r.status = StReject;
      end else begin
        hit = 1'b0;
        for (int k = 0; k < peer_count; k++) begin
          if (!hit && peer_ids[k] == it.sender_id) begin
            peer_seen[k] = it.now_ms;
            hit = 1'b1;
          end
        end
        if (hit) begin
          r.status = StRefresh;
        end else if (peer_count < PeerSlots) begin
          peer_ids[peer_count]  = it.sender_id;
          peer_seen[peer_count] = it.now_ms;
          peer_count++;
          r.status = StAdded;
        end else begin
          r.status = StFull;
        end
      end
    end
    // Ageing pass: survivors slide down and keep their order.
    prev = peer_count;
    kept = 0;
    for (int k = 0; k < prev; k++) begin
      age = it.now_ms - peer_seen[k];
      if (age < timeout_cfg) begin
        peer_ids[kept]  = peer_ids[k];
        peer_seen[kept] = peer_seen[k];
        kept++;
      end
    end
    peer_count     = kept;
    r.peer_total   = 4'(kept);
    r.pruned_total = 4'(prev - kept);
    return r;
  endfunction

  function automatic in_item_t frame_at(logic [31:0] now, logic [7:0] len,
                                        logic [31:0] magic, logic [31:0] id);
    in_item_t it;
    it.action      = 1'b0;
    it.now_ms      = now;
    it.frame_len   = len;
    it.frame_magic = magic;
    it.sender_id   = id;
    return it;
  endfunction

  // A tick carrying well-formed frame fields, which must be ignored.
  function automatic in_item_t tick_at(logic [31:0] now);
    in_item_t it;
    it        = frame_at(now, MinFrameLen, MagicWord, 32'h5A5A_0001);
    it.action = 1'b1;
    return it;
  endfunction

  function automatic logic [31:0] next_step();
    int          r;
    logic [31:0] span;
    r    = $urandom_range(99);
    span = timeout_cfg >> 3;
    if (r < 10) return '0;
    if (r < 80) return $urandom_range(span, 0);
    if (r < 97) return $urandom_range(timeout_cfg, 0);
    return $urandom;
  endfunction

  function automatic in_item_t random_item();
    in_item_t it;
    int       r;
    r          = $urandom_range(99);
    now_cursor = now_cursor + next_step();
    it = frame_at(now_cursor, 8'($urandom_range(250, 13)), MagicWord,
                  id_pool[$urandom_range(PoolSize - 1)]);
    if (r < 8) begin
      it.action      = 1'b1;
      it.frame_len   = 8'($urandom);
      it.frame_magic = $urandom_range(1) ? MagicWord : 32'($urandom);
      it.sender_id   = $urandom;
    end else if (r < 13) begin
      it.frame_len = 8'($urandom_range(12));
    end else if (r < 16) begin
      it.frame_magic = MagicWord ^ (32'd1 << $urandom_range(31));
    end else if (r < 18) begin
      it.frame_magic = $urandom;
    end else if (r < 22) begin
      it.sender_id = own_id_cfg;
    end else if (r < 25) begin
      it.frame_len = 8'($urandom_range(255, 251));
    end
    return it;
  endfunction

  task automatic write_cfg(logic idx, logic [31:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == CfgOwnId) own_id_cfg = val;
    else timeout_cfg = val;
  endtask

  // Checked away from the rising edge so that the driver's updates have settled.
  task automatic wait_drained();
    while (frames_to_send.size() != 0 || start || due_peer_reports.size() != 0 || busy) begin
      @(negedge clk_i);
    end
  endtask

  // Driver: a transaction is taken at an edge where start is high and busy is low.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy) due_peer_reports.push_back(apply_to_peer_table(item_i));
      if (!start || !busy) begin
        if (frames_to_send.size() != 0 && !(sender_gaps && $urandom_range(99) < 35)) begin
          item_i <= frames_to_send.pop_front();
          start  <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: results are strobed for one cycle and cannot be held off.
  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni && done_o) begin
      if (due_peer_reports.size() == 0) begin
        flag_mismatch("result with nothing outstanding, status", result_o.status, 0);
      end else begin
        want = due_peer_reports.pop_front();
        if (result_o.status !== want.status)
          flag_mismatch("status", result_o.status, want.status);
        if (result_o.peer_total !== want.peer_total)
          flag_mismatch("peer_total", result_o.peer_total, want.peer_total);
        if (result_o.pruned_total !== want.pruned_total)
          flag_mismatch("pruned_total", result_o.pruned_total, want.pruned_total);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    logic [31:0] own;
    logic [31:0] tmo;
    int          n_items;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part under the reset settings: own ID zero, timeout 10000.
    frames_to_send.push_back(tick_at(32'd100));
    frames_to_send.push_back(frame_at(32'd100, 8'd12, MagicWord, 32'h11));
    frames_to_send.push_back(frame_at(32'd100, 8'd0, MagicWord, 32'h11));
    frames_to_send.push_back(frame_at(32'd100, 8'd13, MagicWord, 32'h11));
    frames_to_send.push_back(frame_at(32'd100, 8'd250, MagicWord, 32'hFFFF_FFFF));
    frames_to_send.push_back(frame_at(32'd100, 8'd255, MagicWord, 32'h22));
    frames_to_send.push_back(frame_at(32'd100, 8'd40, MagicWord ^ 32'd1, 32'h33));
    frames_to_send.push_back(frame_at(32'd100, 8'd40, ~MagicWord, 32'h33));
    frames_to_send.push_back(frame_at(32'd100, 8'd40, MagicWord, 32'h0));
    frames_to_send.push_back(frame_at(32'd200, 8'd20, MagicWord, 32'h11));
    for (int k = 3; k < 8; k++) begin
      frames_to_send.push_back(frame_at(32'd300, 8'd20, MagicWord, 32'(k * 32'h11)));
    end
    frames_to_send.push_back(frame_at(32'd300, 8'd20, MagicWord, 32'h88));
    // Two entries sit one millisecond short of the timeout, then reach it.
    frames_to_send.push_back(tick_at(32'd10099));
    frames_to_send.push_back(tick_at(32'd10100));
    frames_to_send.push_back(frame_at(32'd10100, 8'd20, MagicWord, 32'h88));
    // Across the wrap of the millisecond counter the age stays small.
    frames_to_send.push_back(frame_at(32'hFFFF_FFF0, 8'd20, MagicWord, 32'h99));
    frames_to_send.push_back(tick_at(32'h0000_0010));
    frames_to_send.push_back(frame_at(32'h0000_0020, 8'd20, MagicWord, 32'h99));
    frames_to_send.push_back(tick_at(32'h0));

    for (int ph = 0; ph < 7; ph++) begin
      // The sender holds back here until every outstanding result has come.
      wait_drained();
      for (int k = 0; k < PoolSize; k++) id_pool[k] = $urandom;
      if (ph % 2 == 0) begin
        id_pool[0] = 32'h0;
        id_pool[1] = 32'hFFFF_FFFF;
      end
      sender_gaps = 1'b1;
      n_items     = 300;
      case (ph)
        0: begin
          own     = 32'h0;
          tmo     = 32'h0;
          n_items = 150;
        end
        1: begin
          own = $urandom;
          tmo = TimeoutReset;
        end
        2: begin
          own = id_pool[3];
          tmo = 32'd50;
        end
        3: begin
          own = $urandom;
          tmo = 32'd1;
        end
        4: begin
          own         = 32'hFFFF_FFFF;
          tmo         = 32'hFFFF_FFFF;
          sender_gaps = 1'b0;
        end
        5: begin
          own = $urandom;
          tmo = $urandom_range(5000, 2);
        end
        default: begin
          own = 32'h0;
          tmo = 32'd400;
        end
      endcase
      write_cfg(CfgOwnId, own);
      write_cfg(CfgTimeout, tmo);
      now_cursor = $urandom_range(1) ? 32'($urandom) : 32'hFFFF_0000;
      for (int k = 0; k < n_items; k++) frames_to_send.push_back(random_item());
    end

    wait_drained();
    repeat (20) @(posedge clk_i);
    if (due_peer_reports.size() != 0) begin
      flag_mismatch("results never delivered", due_peer_reports.size(), 0);
    end
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
